### design/ase_pkg.sv
// shared types and constants for the ascending sort engine
// no dependencies; compiled first
package ase_pkg;

  localparam int DATA_W    = 32;
  localparam int ASE_DEPTH = 32;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ase_state_t;

  // per-cycle command from the controller to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value into the sorted chain
    logic pop;     // shift the chain one cell toward cell 0
  } ase_ctrl_t;

endpackage

### design/ase_in_if.sv
// input channel of the sort engine: one value per item, last marks end of set
// depends on ase_pkg
interface ase_in_if;
  import ase_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

### design/ase_out_if.sv
// output channel of the sort engine: one sorted value per item
// depends on ase_pkg
interface ase_out_if;
  import ase_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic              final_res;
  logic              overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

### design/ase_cell.sv
// one cell of the insertion sort chain: holds one value and its valid bit
// depends on ase_pkg
module ase_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  ase_pkg::ase_ctrl_t                cmd,
  input  logic signed [ase_pkg::DATA_W-1:0] new_value,
  input  logic signed [ase_pkg::DATA_W-1:0] left_val,
  input  logic                              left_valid,
  input  logic                              left_ins,
  input  logic signed [ase_pkg::DATA_W-1:0] right_val,
  input  logic                              right_valid,
  output logic signed [ase_pkg::DATA_W-1:0] val,
  output logic                              valid,
  output logic                              ins
);
  import ase_pkg::*;

  // insertion point lies at or before this cell
  assign ins = !valid || (new_value < val);

  // valid bit: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.insert) begin
      if (left_ins) begin
        valid <= left_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end
  end

  // held value: shift right on insert past here, shift left on pop
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      val <= right_val;
    end else if (cmd.insert) begin
      if (left_ins) begin
        val <= left_val;
      end else if (ins) begin
        val <= new_value;
      end
    end
  end

endmodule

### design/ase_ctrl.sv
// load/drain controller and output register of the sort engine
// depends on ase_pkg
module ase_ctrl #(
  parameter int DEPTH = ase_pkg::ASE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_last,
  output logic                              in_ready,
  input  logic signed [ase_pkg::DATA_W-1:0] head_val,
  output ase_pkg::ase_ctrl_t                cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ase_pkg::DATA_W-1:0] out_value,
  output logic                              out_final,
  output logic                              out_overflow
);
  import ase_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  ase_state_t       state, state_next;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             in_fire;
  logic             full;
  logic             last_pop;

  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign last_pop = cmd.pop && (count == CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (in_fire && in_last) state_next = ST_DRAIN;
      ST_DRAIN: if (last_pop)           state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready   = 1'b0;
    cmd.insert = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid && !full;
      end
      ST_DRAIN: begin
        cmd.pop = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // state, fill count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
      if (in_fire && full) begin
        dropped <= 1'b1;
      end else if (last_pop) begin
        dropped <= 1'b0;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_value    <= head_val;
      out_final    <= last_pop;
      out_overflow <= dropped;
    end
  end

endmodule

### design/ascending_sort_engine_top.sv
// top level of the ascending sort engine: controller plus a chain of sort cells
// depends on ase_pkg, ase_in_if, ase_out_if, ase_cell, ase_ctrl
//
// Usage:
//   sort_in takes one signed value per item; an item with last set ends the set.
//   Items are taken one per cycle while loading. Each accepted value is placed
//   in order into a chain of DEPTH cells by a compare in every cell, so the set
//   is already sorted when the last item arrives. Values past DEPTH are dropped
//   and overflow is then set on every result of that set.
//   After the last item, sort_in.ready is low while the chain drains through
//   sort_out, smallest first, one result per cycle when the receiver is ready;
//   the first result is valid once the controller is in drain and has registered the head.
//   final_res marks the last (greatest) result; loading resumes right after it
//   leaves the chain, even while it still waits in the output register.
//   Loading and draining of a set never overlap, and the drain rate is set
//   by the single shift-out port at cell 0.
//   When the receiver stalls, the output register holds and the chain waits.
//   Reset (rst, synchronous) empties the chain and returns to loading.
module ascending_sort_engine_top #(
  parameter int DEPTH = ase_pkg::ASE_DEPTH
) (
  input logic           clk,
  input logic           rst,
  ase_in_if.sink        sort_in,
  ase_out_if.source     sort_out
);
  import ase_pkg::*;

  ase_ctrl_t                cmd;
  logic signed [DATA_W-1:0] cell_val   [DEPTH];
  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_ins;

  // controller and output register
  ase_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sort_in.valid),
    .in_last      (sort_in.last),
    .in_ready     (sort_in.ready),
    .head_val     (cell_val[0]),
    .cmd          (cmd),
    .out_valid    (sort_out.valid),
    .out_ready    (sort_out.ready),
    .out_value    (sort_out.sorted_value),
    .out_final    (sort_out.final_res),
    .out_overflow (sort_out.overflow)
  );

  // chain of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic                     left_valid;
    logic                     left_ins;
    logic signed [DATA_W-1:0] right_val;
    logic                     right_valid;

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_valid = 1'b0;
      assign left_ins   = 1'b0;
    end else begin : g_mid_l
      assign left_val   = cell_val[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val   = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ase_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .new_value   (sort_in.value),
      .left_val    (left_val),
      .left_valid  (left_valid),
      .left_ins    (left_ins),
      .right_val   (right_val),
      .right_valid (right_valid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .ins         (cell_ins[i])
    );
  end

  // filling and draining never happen in the same cycle
  a_no_insert_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && cmd.pop))
    else $error("insert and pop in the same cycle");

  // occupied cells always form a contiguous run starting at cell 0
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid & (cell_valid + DEPTH'(1))) == '0))
    else $error("gap in the cell chain");

  // an insert always leaves cell 0 occupied
  a_insert_head: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> cell_valid[0])
    else $error("cell 0 empty after insert");

  // the final result leaves the chain empty
  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.pop) && sort_out.valid && sort_out.final_res) |-> (cell_valid == '0))
    else $error("chain not empty after final result");

endmodule
